// ===== rtl/b40tc_pkg.sv =====
// Shared types, constants and character mapping functions of the base-40 triplet codec.
package b40tc_pkg;

    localparam int unsigned RADIX = 40;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic [5:0] DIG_NUL        = 6'd0;
    localparam logic [5:0] DIG_ZERO       = 6'd1;
    localparam logic [5:0] DIG_NINE       = 6'd10;
    localparam logic [5:0] DIG_LETTER     = 6'd11;
    localparam logic [5:0] DIG_SPACE      = 6'd37;
    localparam logic [5:0] DIG_AT         = 6'd38;
    localparam logic [5:0] DIG_UNDERSCORE = 6'd39;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_AT         = 8'h40;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // Reciprocal of five for a 13-bit dividend, scaled by 2^18.
    localparam logic [15:0] RECIP5_WIDE  = 16'd52429;
    localparam int unsigned RECIP5_SHIFT = 18;
    // Reciprocal of five for an 8-bit dividend, scaled by 2^10.
    localparam logic [7:0]  RECIP5_NARROW = 8'd205;
    localparam int unsigned RECIP5_NSHIFT = 10;

    typedef struct packed {
        logic       func;
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic [7:0] third_char;
        logic [7:0] packed_high;
        logic [7:0] packed_low;
    } item_t;

    typedef struct packed {
        logic        func;
        logic        bad;
        logic [5:0]  dig_a;
        logic [5:0]  dig_b;
        logic [5:0]  dig_c;
        logic [10:0] quo;
    } stage1_t;

    typedef struct packed {
        logic        func;
        logic        bad;
        logic [5:0]  dig_a;
        logic [5:0]  dig_b;
        logic [5:0]  dig_c;
        logic [10:0] part;
    } stage2_t;

    typedef struct packed {
        logic       bad;
        logic [5:0] digit;
    } map_t;

    function automatic map_t byte_to_digit(input logic [7:0] c);
        map_t m;
        m.bad = 1'b0;
        priority if (c == CH_NUL)
            m.digit = DIG_NUL;
        else if (c >= CH_ZERO && c <= CH_NINE)
            m.digit = 6'(c - CH_ZERO) + DIG_ZERO;
        else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            m.digit = 6'(c - CH_LOWER_A) + DIG_LETTER;
        else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            m.digit = 6'(c - CH_UPPER_A) + DIG_LETTER;
        else if (c == CH_SPACE)
            m.digit = DIG_SPACE;
        else if (c == CH_AT)
            m.digit = DIG_AT;
        else if (c == CH_UNDERSCORE)
            m.digit = DIG_UNDERSCORE;
        else
        begin
            m.digit = DIG_UNDERSCORE;
            m.bad   = 1'b1;
        end
        return m;
    endfunction

    function automatic logic [7:0] digit_to_byte(input logic [5:0] d);
        logic [7:0] c;
        priority if (d == DIG_NUL)
            c = CH_NUL;
        else if (d <= DIG_NINE)
            c = {2'b00, d - DIG_ZERO} + CH_ZERO;
        else if (d == DIG_SPACE)
            c = CH_SPACE;
        else if (d == DIG_AT)
            c = CH_AT;
        else if (d == DIG_UNDERSCORE)
            c = CH_UNDERSCORE;
        else
            c = {2'b00, d - DIG_LETTER} + CH_LOWER_A;
        return c;
    endfunction

endpackage

// ===== rtl/b40tc_map.sv =====
// First pipeline stage: character to digit mapping and the low base-40 digit split.
module b40tc_map
    import b40tc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  item_t   in_item,
    output logic    out_valid,
    output stage1_t out_data
);

    logic        valid_reg;
    stage1_t     data_reg;
    stage1_t     data_next;
    map_t        m1;
    map_t        m2;
    map_t        m3;
    logic [15:0] word;
    logic [12:0] w3;
    logic [28:0] prod;
    logic [10:0] q1;
    logic [13:0] q1x5;
    logic [2:0]  r5;

    always_comb
    begin
        m1   = byte_to_digit(in_item.first_char);
        m2   = byte_to_digit(in_item.second_char);
        m3   = byte_to_digit(in_item.third_char);
        word = {in_item.packed_high, in_item.packed_low};
        w3   = word[15:3];
        prod = 29'(w3) * 29'(RECIP5_WIDE);
        q1   = 11'(prod >> RECIP5_SHIFT);
        q1x5 = 14'(q1) * 14'd5;
        r5   = 3'(14'(w3) - q1x5);
        data_next.func = in_item.func;
        if (in_item.func == FUNC_ENCODE)
        begin
            data_next.bad   = m1.bad | m2.bad | m3.bad;
            data_next.dig_a = m1.digit;
            data_next.dig_b = m2.digit;
            data_next.dig_c = m3.digit;
            data_next.quo   = '0;
        end
        else
        begin
            data_next.bad   = 1'b0;
            data_next.dig_a = {r5, word[2:0]};
            data_next.dig_b = '0;
            data_next.dig_c = '0;
            data_next.quo   = q1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/b40tc_fold.sv =====
// Second pipeline stage: partial word sum on encode, upper digit split on decode.
module b40tc_fold
    import b40tc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  stage1_t in_data,
    output logic    out_valid,
    output stage2_t out_data
);

    logic        valid_reg;
    stage2_t     data_reg;
    stage2_t     data_next;
    logic [7:0]  y;
    logic [15:0] prod;
    logic [5:0]  q2;
    logic [8:0]  q2x5;
    logic [2:0]  r5;
    logic [5:0]  d3;

    always_comb
    begin
        y    = in_data.quo[10:3];
        prod = 16'(y) * 16'(RECIP5_NARROW);
        q2   = 6'(prod >> RECIP5_NSHIFT);
        q2x5 = 9'(q2) * 9'd5;
        r5   = 3'(9'(y) - q2x5);
        d3   = (q2 >= 6'(RADIX)) ? 6'(q2 - 6'(RADIX)) : q2;
        data_next.func = in_data.func;
        data_next.bad  = in_data.bad;
        data_next.dig_a = in_data.dig_a;
        if (in_data.func == FUNC_ENCODE)
        begin
            data_next.dig_b = in_data.dig_b;
            data_next.dig_c = in_data.dig_c;
            data_next.part  = 11'(in_data.dig_a) + (11'(in_data.dig_b) << 5)
                              + (11'(in_data.dig_b) << 3);
        end
        else
        begin
            data_next.dig_b = {r5, in_data.quo[2:0]};
            data_next.dig_c = d3;
            data_next.part  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/b40tc_emit.sv =====
// Third pipeline stage: final word sum or digit to character mapping, into the result register.
module b40tc_emit
    import b40tc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  stage2_t    in_data,
    output logic       done,
    output logic [7:0] packed_high_out,
    output logic [7:0] packed_low_out,
    output logic [7:0] first_char_out,
    output logic [7:0] second_char_out,
    output logic [7:0] third_char_out,
    output logic       bad_char
);

    logic        done_reg;
    logic [15:0] word_reg;
    logic [15:0] word_next;
    logic [7:0]  c1_reg;
    logic [7:0]  c1_next;
    logic [7:0]  c2_reg;
    logic [7:0]  c2_next;
    logic [7:0]  c3_reg;
    logic [7:0]  c3_next;
    logic        bad_reg;
    logic [15:0] d3w;

    always_comb
    begin
        d3w = 16'(in_data.dig_c);
        if (in_data.func == FUNC_ENCODE)
        begin
            word_next = 16'(in_data.part) + (d3w << 10) + (d3w << 9) + (d3w << 6);
            c1_next   = '0;
            c2_next   = '0;
            c3_next   = '0;
        end
        else
        begin
            word_next = '0;
            c1_next   = digit_to_byte(in_data.dig_a);
            c2_next   = digit_to_byte(in_data.dig_b);
            c3_next   = digit_to_byte(in_data.dig_c);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            word_reg <= word_next;
            c1_reg   <= c1_next;
            c2_reg   <= c2_next;
            c3_reg   <= c3_next;
            bad_reg  <= in_data.bad;
        end
    end

    assign done            = done_reg;
    assign packed_high_out = word_reg[15:8];
    assign packed_low_out  = word_reg[7:0];
    assign first_char_out  = c1_reg;
    assign second_char_out = c2_reg;
    assign third_char_out  = c3_reg;
    assign bad_char        = bad_reg;

endmodule

// ===== rtl/base40_triplet_codec_core.sv =====
// Top level of the base-40 triplet codec: three-stage pipeline from command to result strobe.
//
//   Channel  | Handshake             | Payload
//   ---------+-----------------------+-------------------------------------------------
//   command  | start in, busy out    | func, first/second/third_char, packed_high/low
//   result   | done out (strobe)     | packed_high/low_out, first/second/third_char_out,
//            |                       | bad_char
//
// Each transfer yields one result, registered through the map, fold and emit stages; one command may be
// taken every cycle, so the throughput is one item per clock.
// The three register stages are: mapping and first divide by 40,
// second divide by 40 or partial sum, and final sum or character mapping.
// Reset clears the stage valid bits; busy stays low since the result side cannot stall.
module base40_triplet_codec_core
    import b40tc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       func,
    input  logic [7:0] first_char,
    input  logic [7:0] second_char,
    input  logic [7:0] third_char,
    input  logic [7:0] packed_high,
    input  logic [7:0] packed_low,
    output logic       done,
    output logic [7:0] packed_high_out,
    output logic [7:0] packed_low_out,
    output logic [7:0] first_char_out,
    output logic [7:0] second_char_out,
    output logic [7:0] third_char_out,
    output logic       bad_char
);

    item_t   item;
    logic    accept;
    logic    s1_valid;
    stage1_t s1_data;
    logic    s2_valid;
    stage2_t s2_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign item.func        = func;
    assign item.first_char  = first_char;
    assign item.second_char = second_char;
    assign item.third_char  = third_char;
    assign item.packed_high = packed_high;
    assign item.packed_low  = packed_low;

    b40tc_map u_map
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_item   (item),
        .out_valid (s1_valid),
        .out_data  (s1_data)
    );

    b40tc_fold u_fold
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_data  (s2_data)
    );

    b40tc_emit u_emit
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s2_valid),
        .in_data         (s2_data),
        .done            (done),
        .packed_high_out (packed_high_out),
        .packed_low_out  (packed_low_out),
        .first_char_out  (first_char_out),
        .second_char_out (second_char_out),
        .third_char_out  (third_char_out),
        .bad_char        (bad_char)
    );

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid)
        else $error("accepted command did not enter the first stage");

    a_stage1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid |=> s2_valid)
        else $error("first stage item did not advance");

    a_stage2_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid |=> done)
        else $error("second stage item did not produce a result");

    a_bad_is_encode: assert property (@(posedge clk) disable iff (!rst_n)
        done && bad_char |-> first_char_out == 8'h00 && second_char_out == 8'h00
                             && third_char_out == 8'h00)
        else $error("bad character flag raised on a decode result");

endmodule
